/* rtl/two_centroid_online_classifier_defines.svh */
// Assertion macros for the two-centroid classifier.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TWO_CENTROID_ONLINE_CLASSIFIER_DEFINES_SVH
`define TWO_CENTROID_ONLINE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCOC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcoc same-cycle check failed");
`define TCOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcoc next-cycle check failed");
`else
`define TCOC_ASSERT_SAME(lbl, ante, cons)
`define TCOC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/tcoc_pkg.sv */
// Shared types, widths and codes for the two-centroid classifier.
// No dependencies; used by every other RTL file but the assertion header.
package tcoc_pkg;

  localparam int VecLen  = 4;
  localparam int ElemW   = 16;
  localparam int CmdW    = 3;
  localparam int LabelW  = 2;
  localparam int ThreshW = 15;
  localparam int RateW   = 16;
  localparam int T2W     = 2 * ThreshW;
  localparam int SqW     = 2 * ElemW;
  localparam int DistW   = SqW + 2;

  localparam logic [CmdW-1:0] CmdClassify = 3'd0;
  localparam logic [CmdW-1:0] CmdTrainA   = 3'd1;
  localparam logic [CmdW-1:0] CmdTrainB   = 3'd2;
  localparam logic [CmdW-1:0] CmdLoadA    = 3'd3;
  localparam logic [CmdW-1:0] CmdLoadB    = 3'd4;

  localparam logic [LabelW-1:0] LabelNone = 2'd0;
  localparam logic [LabelW-1:0] LabelA    = 2'd1;
  localparam logic [LabelW-1:0] LabelB    = 2'd2;

  localparam logic [ThreshW-1:0] ThreshReset = 15'd410;
  localparam logic [RateW-1:0]   RateReset   = 16'd3277;

  typedef logic [VecLen-1:0][ElemW-1:0] vec_t;

  typedef struct packed {
    logic [T2W-1:0]   t2;
    logic [RateW-1:0] rate;
  } cfg_t;

  typedef struct packed {
    logic [SqW-1:0]   sq_a;
    logic [SqW-1:0]   sq_b;
    logic [ElemW-1:0] mov_a;
    logic [ElemW-1:0] mov_b;
  } lane_res_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    vec_t              cent_a;
    vec_t              cent_b;
  } merge_res_t;

endpackage

/* rtl/tcoc_in_if.sv */
// Input channel of the classifier: command and feature vector.
// Depends on tcoc_pkg for field widths.
interface tcoc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcoc_pkg::CmdW-1:0]     cmd;
  logic signed [tcoc_pkg::ElemW-1:0] elem0;
  logic signed [tcoc_pkg::ElemW-1:0] elem1;
  logic signed [tcoc_pkg::ElemW-1:0] elem2;
  logic signed [tcoc_pkg::ElemW-1:0] elem3;

  modport source (output valid, cmd, elem0, elem1, elem2, elem3, input ready);
  modport sink (input valid, cmd, elem0, elem1, elem2, elem3, output ready);
endinterface

/* rtl/tcoc_out_if.sv */
// Result channel of the classifier: label and both centroids.
// Depends on tcoc_pkg for field widths.
interface tcoc_out_if;
  logic                              valid;
  logic                              ready;
  logic [tcoc_pkg::LabelW-1:0]       label;
  logic signed [tcoc_pkg::ElemW-1:0] cent_a0;
  logic signed [tcoc_pkg::ElemW-1:0] cent_a1;
  logic signed [tcoc_pkg::ElemW-1:0] cent_a2;
  logic signed [tcoc_pkg::ElemW-1:0] cent_a3;
  logic signed [tcoc_pkg::ElemW-1:0] cent_b0;
  logic signed [tcoc_pkg::ElemW-1:0] cent_b1;
  logic signed [tcoc_pkg::ElemW-1:0] cent_b2;
  logic signed [tcoc_pkg::ElemW-1:0] cent_b3;

  modport source (output valid, label, cent_a0, cent_a1, cent_a2, cent_a3,
                  cent_b0, cent_b1, cent_b2, cent_b3, input ready);
  modport sink (input valid, label, cent_a0, cent_a1, cent_a2, cent_a3,
                cent_b0, cent_b1, cent_b2, cent_b3, output ready);
endinterface

/* rtl/two_centroid_online_classifier.sv */
// Channel  Direction  Contents
// in_ch    sink       cmd, elem0..elem3 (valid/ready)
// out_ch   source     label, cent_a0..cent_a3, cent_b0..cent_b3 (valid/ready)
// APB      slave      match_threshold at 0x0, learn_rate at 0x4
//
// One item per cycle while the output is empty or being read: four lanes compute
// squares and centroid moves combinationally, and the centroid registers close
// the loop from one item to the next; each result is registered on its transfer.
// A new item is taken outside reset whenever the output register is empty or being read.
// Synchronous active-low reset clears both centroids and restores the registers.
// Depends on tcoc_pkg, tcoc_in_if, tcoc_out_if, tcoc_cfg, tcoc_lane, tcoc_merge.
`include "two_centroid_online_classifier_defines.svh"
module two_centroid_online_classifier (
  input  logic        clk,
  input  logic        rst_n,
  tcoc_in_if.sink     in_ch,
  tcoc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcoc_pkg::cfg_t       cfg;
  tcoc_pkg::vec_t       x;
  tcoc_pkg::vec_t       cent_a_r, cent_a_nxt;
  tcoc_pkg::vec_t       cent_b_r, cent_b_nxt;
  tcoc_pkg::lane_res_t [tcoc_pkg::VecLen-1:0] lanes;
  tcoc_pkg::merge_res_t merged;
  logic                 out_valid_r, out_valid_nxt;
  logic [tcoc_pkg::LabelW-1:0] out_label_r;
  logic                 in_fire;

  tcoc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign x[0] = in_ch.elem0;
  assign x[1] = in_ch.elem1;
  assign x[2] = in_ch.elem2;
  assign x[3] = in_ch.elem3;

  for (genvar i = 0; i < tcoc_pkg::VecLen; i++) begin : g_lane
    tcoc_lane u_lane (
      .x    (x[i]),
      .ca   (cent_a_r[i]),
      .cb   (cent_b_r[i]),
      .rate (cfg.rate),
      .res  (lanes[i])
    );
  end

  tcoc_merge u_merge (
    .cmd    (in_ch.cmd),
    .x      (x),
    .cent_a (cent_a_r),
    .cent_b (cent_b_r),
    .t2     (cfg.t2),
    .lanes  (lanes),
    .res    (merged)
  );

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    cent_a_nxt    = cent_a_r;
    cent_b_nxt    = cent_b_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_fire) begin
      cent_a_nxt    = merged.cent_a;
      cent_b_nxt    = merged.cent_b;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cent_a_r    <= '0;
      cent_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cent_a_r    <= cent_a_nxt;
      cent_b_r    <= cent_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The label is only loaded on a transfer; the centroid fields always show
  // the live state, which only moves on a transfer too.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_label_r <= merged.label;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.label   = out_label_r;
  assign out_ch.cent_a0 = cent_a_r[0];
  assign out_ch.cent_a1 = cent_a_r[1];
  assign out_ch.cent_a2 = cent_a_r[2];
  assign out_ch.cent_a3 = cent_a_r[3];
  assign out_ch.cent_b0 = cent_b_r[0];
  assign out_ch.cent_b1 = cent_b_r[1];
  assign out_ch.cent_b2 = cent_b_r[2];
  assign out_ch.cent_b3 = cent_b_r[3];

  `TCOC_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r)
  `TCOC_ASSERT_NEXT(a_state_moves_on_transfer, !in_fire, $stable(cent_a_r) && $stable(cent_b_r))
  `TCOC_ASSERT_NEXT(a_unknown_keeps_state, in_fire && merged.label == tcoc_pkg::LabelNone, $stable(cent_a_r) && $stable(cent_b_r))
  `TCOC_ASSERT_SAME(a_label_legal, out_valid_r, out_label_r != 2'd3)

endmodule

/* rtl/tcoc_cfg.sv */
// APB register file for the classifier: match threshold and learning rate.
// Depends on tcoc_pkg; keeps the threshold square ready for the distance compare.
module tcoc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output tcoc_pkg::cfg_t            cfg
);

  logic [tcoc_pkg::ThreshW-1:0] thresh_r, thresh_nxt;
  logic [tcoc_pkg::T2W-1:0]     t2_r, t2_nxt;
  logic [tcoc_pkg::RateW-1:0]   rate_r, rate_nxt;
  logic                         wr_en;
  logic [tcoc_pkg::ThreshW-1:0] wr_thresh;

  // Only address bit 2 selects a register; the low bits are ignored.
  assign wr_en     = psel && penable && pwrite && pready;
  assign wr_thresh = pwdata[tcoc_pkg::ThreshW-1:0];
  assign pready    = 1'b1;

  always_comb begin
    thresh_nxt = thresh_r;
    t2_nxt     = t2_r;
    rate_nxt   = rate_r;
    if (wr_en && !paddr[2]) begin
      thresh_nxt = wr_thresh;
      t2_nxt     = tcoc_pkg::T2W'(wr_thresh) * tcoc_pkg::T2W'(wr_thresh);
    end
    if (wr_en && paddr[2]) begin
      rate_nxt = pwdata[tcoc_pkg::RateW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= tcoc_pkg::ThreshReset;
      t2_r     <= tcoc_pkg::T2W'(tcoc_pkg::ThreshReset) * tcoc_pkg::T2W'(tcoc_pkg::ThreshReset);
      rate_r   <= tcoc_pkg::RateReset;
    end else begin
      thresh_r <= thresh_nxt;
      t2_r     <= t2_nxt;
      rate_r   <= rate_nxt;
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {{(32 - tcoc_pkg::RateW){1'b0}}, rate_r};
    end else begin
      prdata = {{(32 - tcoc_pkg::ThreshW){1'b0}}, thresh_r};
    end
  end

  assign cfg.t2   = t2_r;
  assign cfg.rate = rate_r;

endmodule

/* rtl/tcoc_lane.sv */
// One vector element of the classifier: squared distance terms and the
// moved centroid values for both centroids. Depends on tcoc_pkg.
module tcoc_lane (
  input  logic [tcoc_pkg::ElemW-1:0] x,
  input  logic [tcoc_pkg::ElemW-1:0] ca,
  input  logic [tcoc_pkg::ElemW-1:0] cb,
  input  logic [tcoc_pkg::RateW-1:0] rate,
  output tcoc_pkg::lane_res_t        res
);

  localparam int DW = tcoc_pkg::ElemW + 1;
  localparam int PW = DW + tcoc_pkg::RateW + 1;
  localparam int StepW = PW - tcoc_pkg::RateW;
  localparam int SumW = StepW + 1;

  logic signed [DW-1:0]        d_a, d_b;
  logic signed [2*DW-1:0]      sq_a, sq_b;
  logic signed [PW-1:0]        p_a, p_b;
  logic signed [tcoc_pkg::RateW:0] rate_s;

  // c + floor(p / 2^16), clamped to the signed element range.
  function automatic logic [tcoc_pkg::ElemW-1:0] move_elem(
    input logic [tcoc_pkg::ElemW-1:0] c,
    input logic signed [PW-1:0]       p
  );
    logic signed [StepW-1:0] step;
    logic signed [SumW-1:0]  sum;
    logic signed [SumW-1:0]  hi;
    logic signed [SumW-1:0]  lo;
    step = p[PW-1:tcoc_pkg::RateW];
    sum  = $signed({{(SumW - tcoc_pkg::ElemW){c[tcoc_pkg::ElemW-1]}}, c})
         + $signed({step[StepW-1], step});
    hi   = SumW'(32767);
    lo   = -SumW'(32768);
    if (sum > hi) begin
      move_elem = 16'h7fff;
    end else if (sum < lo) begin
      move_elem = 16'h8000;
    end else begin
      move_elem = sum[tcoc_pkg::ElemW-1:0];
    end
  endfunction

  assign d_a    = $signed({x[tcoc_pkg::ElemW-1], x}) - $signed({ca[tcoc_pkg::ElemW-1], ca});
  assign d_b    = $signed({x[tcoc_pkg::ElemW-1], x}) - $signed({cb[tcoc_pkg::ElemW-1], cb});
  assign sq_a   = d_a * d_a;
  assign sq_b   = d_b * d_b;
  assign rate_s = $signed({1'b0, rate});
  assign p_a    = rate_s * d_a;
  assign p_b    = rate_s * d_b;

  // A square of a 17-bit difference stays below 2^32.
  assign res.sq_a  = sq_a[tcoc_pkg::SqW-1:0];
  assign res.sq_b  = sq_b[tcoc_pkg::SqW-1:0];
  assign res.mov_a = move_elem(ca, p_a);
  assign res.mov_b = move_elem(cb, p_b);

endmodule

/* rtl/tcoc_merge.sv */
// Merging stage: sums the lane squares, tests the threshold and picks the
// new centroids and label for the command. Depends on tcoc_pkg.
module tcoc_merge (
  input  logic [tcoc_pkg::CmdW-1:0]  cmd,
  input  tcoc_pkg::vec_t             x,
  input  tcoc_pkg::vec_t             cent_a,
  input  tcoc_pkg::vec_t             cent_b,
  input  logic [tcoc_pkg::T2W-1:0]   t2,
  input  tcoc_pkg::lane_res_t [tcoc_pkg::VecLen-1:0] lanes,
  output tcoc_pkg::merge_res_t       res
);

  logic [tcoc_pkg::DistW-1:0] dist_a, dist_b, t2_ext;
  logic                       hit_a, hit_b;
  tcoc_pkg::vec_t             mov_a, mov_b;

  always_comb begin
    dist_a = '0;
    dist_b = '0;
    for (int i = 0; i < tcoc_pkg::VecLen; i++) begin
      dist_a = dist_a + tcoc_pkg::DistW'(lanes[i].sq_a);
      dist_b = dist_b + tcoc_pkg::DistW'(lanes[i].sq_b);
      mov_a[i] = lanes[i].mov_a;
      mov_b[i] = lanes[i].mov_b;
    end
  end

  assign t2_ext = tcoc_pkg::DistW'(t2);
  assign hit_a  = dist_a < t2_ext;
  assign hit_b  = dist_b < t2_ext;

  always_comb begin
    res.label  = tcoc_pkg::LabelNone;
    res.cent_a = cent_a;
    res.cent_b = cent_b;
    unique case (cmd)
      tcoc_pkg::CmdClassify: begin
        // Centroid A wins whenever both are within the threshold.
        if (hit_a) begin
          res.label  = tcoc_pkg::LabelA;
          res.cent_a = mov_a;
        end else if (hit_b) begin
          res.label  = tcoc_pkg::LabelB;
          res.cent_b = mov_b;
        end
      end
      tcoc_pkg::CmdTrainA: begin
        res.label  = tcoc_pkg::LabelA;
        res.cent_a = mov_a;
      end
      tcoc_pkg::CmdTrainB: begin
        res.label  = tcoc_pkg::LabelB;
        res.cent_b = mov_b;
      end
      tcoc_pkg::CmdLoadA: begin
        res.label  = tcoc_pkg::LabelA;
        res.cent_a = x;
      end
      tcoc_pkg::CmdLoadB: begin
        res.label  = tcoc_pkg::LabelB;
        res.cent_b = x;
      end
      default: begin
        res.label = tcoc_pkg::LabelNone;
      end
    endcase
  end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the two-centroid online classifier.
// Depends on tcoc_pkg, tcoc_in_if, tcoc_out_if and the classifier top level.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] AddrThresh = 3'h0;
  localparam logic [2:0] AddrRate   = 3'h4;
  localparam logic [tcoc_pkg::CmdW-1:0] CmdFirstUndef = tcoc_pkg::CmdLoadB + 3'd1;
  localparam logic [tcoc_pkg::CmdW-1:0] CmdLastUndef  = {tcoc_pkg::CmdW{1'b1}};
  localparam logic [tcoc_pkg::ElemW-1:0] ElemMax  = 16'h7FFF;
  localparam logic [tcoc_pkg::ElemW-1:0] ElemMin  = 16'h8000;
  localparam logic [tcoc_pkg::ElemW-1:0] ElemZero = 16'h0000;
  localparam int IdleLimit = 2000;
  localparam int PhaseItems = 200;

  typedef enum int {RxFree, RxCoin, RxSparse, RxCycle} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  tcoc_in_if  in_ch ();
  tcoc_out_if out_ch ();

  two_centroid_online_classifier dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the classifier state and its registers.
  logic [tcoc_pkg::ThreshW-1:0] thr_reg;
  logic [tcoc_pkg::RateW-1:0]   rate_reg;
  tcoc_pkg::vec_t               track_a, track_b;
  tcoc_pkg::merge_res_t         pending_results[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int label_hits[3] = '{0, 0, 0};
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_hold = 0;
  int rx_left = 0;
  int rx_phase = 0;
  rx_mode_t rx_mode = RxFree;

  function automatic longint dist_sq(tcoc_pkg::vec_t x, tcoc_pkg::vec_t c);
    longint acc;
    longint d;
    acc = 0;
    for (int i = 0; i < tcoc_pkg::VecLen; i++) begin
      d = longint'($signed(x[i])) - longint'($signed(c[i]));
      acc += d * d;
    end
    return acc;
  endfunction

  function automatic tcoc_pkg::vec_t move_toward(tcoc_pkg::vec_t c, tcoc_pkg::vec_t x);
    tcoc_pkg::vec_t r;
    longint         d, v;
    for (int i = 0; i < tcoc_pkg::VecLen; i++) begin
      d = longint'($signed(x[i])) - longint'($signed(c[i]));
      // Arithmetic shift of a signed product rounds toward minus infinity.
      v = longint'($signed(c[i])) + ((longint'(rate_reg) * d) >>> 16);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r[i] = v[tcoc_pkg::ElemW-1:0];
    end
    return r;
  endfunction

  function automatic tcoc_pkg::merge_res_t classify_and_learn(logic [tcoc_pkg::CmdW-1:0] cmd,
                                                              tcoc_pkg::vec_t x);
    tcoc_pkg::merge_res_t r;
    longint               t2;
    t2 = longint'(thr_reg) * longint'(thr_reg);
    r.label = tcoc_pkg::LabelNone;
    case (cmd)
      tcoc_pkg::CmdClassify: begin
        if (dist_sq(x, track_a) < t2) begin
          track_a = move_toward(track_a, x);
          r.label = tcoc_pkg::LabelA;
        end else if (dist_sq(x, track_b) < t2) begin
          track_b = move_toward(track_b, x);
          r.label = tcoc_pkg::LabelB;
        end
      end
      tcoc_pkg::CmdTrainA: begin
        track_a = move_toward(track_a, x);
        r.label = tcoc_pkg::LabelA;
      end
      tcoc_pkg::CmdTrainB: begin
        track_b = move_toward(track_b, x);
        r.label = tcoc_pkg::LabelB;
      end
      tcoc_pkg::CmdLoadA: begin
        track_a = x;
        r.label = tcoc_pkg::LabelA;
      end
      tcoc_pkg::CmdLoadB: begin
        track_b = x;
        r.label = tcoc_pkg::LabelB;
      end
      default: ;
    endcase
    r.cent_a = track_a;
    r.cent_b = track_b;
    return r;
  endfunction

  function automatic tcoc_pkg::vec_t vec_of(logic [tcoc_pkg::ElemW-1:0] e0,
                                            logic [tcoc_pkg::ElemW-1:0] e1,
                                            logic [tcoc_pkg::ElemW-1:0] e2,
                                            logic [tcoc_pkg::ElemW-1:0] e3);
    return {e3, e2, e1, e0};
  endfunction

  function automatic tcoc_pkg::vec_t random_vec();
    tcoc_pkg::vec_t v;
    for (int i = 0; i < tcoc_pkg::VecLen; i++) v[i] = tcoc_pkg::ElemW'($urandom);
    return v;
  endfunction

  // A vector within +/- span of c on every element, clamped to the Q4.12 range.
  function automatic tcoc_pkg::vec_t near_vec(tcoc_pkg::vec_t c, int span);
    tcoc_pkg::vec_t v;
    int             e;
    for (int i = 0; i < tcoc_pkg::VecLen; i++) begin
      e = int'($signed(c[i])) + int'($urandom_range(0, 2 * span)) - span;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      v[i] = e[tcoc_pkg::ElemW-1:0];
    end
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  // One transfer on the input channel; valid stays high for a following item.
  task automatic send_item(logic [tcoc_pkg::CmdW-1:0] cmd, tcoc_pkg::vec_t x);
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.elem0 <= x[0];
    in_ch.elem1 <= x[1];
    in_ch.elem2 <= x[2];
    in_ch.elem3 <= x[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(classify_and_learn(cmd, x));
    items_sent++;
  endtask

  // Sender bursts: either keep going or drop valid for a random gap.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // APB transfers leave psel high so that back-to-back transfers need no extra step.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == AddrThresh) thr_reg = data[tcoc_pkg::ThreshW-1:0];
    else if (addr == AddrRate) rate_reg = data[tcoc_pkg::RateW-1:0];
    reg_writes++;
  endtask

  task automatic apb_check_read(logic [2:0] addr);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (addr == AddrThresh) ? 32'(thr_reg) : 32'(rate_reg);
    if (prdata !== want)
      report_mismatch($sformatf("register read at %h: got %h, expected %h", addr, prdata, want));
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper bits of the write data are junk; only the register width is kept.
  task automatic configure(logic [tcoc_pkg::ThreshW-1:0] thr, logic [tcoc_pkg::RateW-1:0] rate);
    wait_drained();
    apb_write(AddrThresh, ($urandom & ~32'h7FFF) | 32'(thr));
    apb_write(AddrRate, ($urandom & ~32'hFFFF) | 32'(rate));
    apb_check_read(AddrThresh);
    apb_check_read(AddrRate);
    apb_idle();
  endtask

  task automatic test_reset_state();
    apb_check_read(AddrThresh);
    apb_check_read(AddrRate);
    apb_idle();
    // Both centroids start at zero, so a zero vector matches A.
    send_item(tcoc_pkg::CmdClassify, '0);
  endtask

  task automatic test_commands();
    send_item(tcoc_pkg::CmdLoadA, {tcoc_pkg::VecLen{ElemMax}});
    send_item(tcoc_pkg::CmdLoadB, {tcoc_pkg::VecLen{ElemMin}});
    send_item(tcoc_pkg::CmdClassify, {tcoc_pkg::VecLen{ElemMax}});
    send_item(tcoc_pkg::CmdClassify, {tcoc_pkg::VecLen{ElemMin}});
    send_item(tcoc_pkg::CmdClassify, vec_of(ElemMax, ElemMin, ElemZero, 16'h1000));
    send_item(tcoc_pkg::CmdTrainA, {tcoc_pkg::VecLen{ElemMin}});
    send_item(tcoc_pkg::CmdTrainB, {tcoc_pkg::VecLen{ElemMax}});
    for (logic [tcoc_pkg::CmdW:0] c = {1'b0, CmdFirstUndef}; c <= {1'b0, CmdLastUndef}; c++)
      send_item(c[tcoc_pkg::CmdW-1:0], random_vec());
  endtask

  task automatic test_threshold_edges();
    configure({tcoc_pkg::ThreshW{1'b1}}, {tcoc_pkg::RateW{1'b1}});
    send_item(tcoc_pkg::CmdLoadA, '0);
    send_item(tcoc_pkg::CmdLoadB, {tcoc_pkg::VecLen{ElemMin}});
    // Distance equal to the threshold is not a match; one less is.
    send_item(tcoc_pkg::CmdClassify, vec_of(ElemMax, ElemZero, ElemZero, ElemZero));
    send_item(tcoc_pkg::CmdClassify, vec_of(ElemMax - 16'd1, ElemZero, ElemZero, ElemZero));
    configure('0, tcoc_pkg::RateReset);
    send_item(tcoc_pkg::CmdClassify, track_a);
    send_item(tcoc_pkg::CmdClassify, track_b);
    configure(tcoc_pkg::ThreshReset, '0);
    send_item(tcoc_pkg::CmdTrainA, '0);
    send_item(tcoc_pkg::CmdTrainB, random_vec());
  endtask

  task automatic test_random_stream();
    logic [tcoc_pkg::ThreshW-1:0] thr;
    logic [tcoc_pkg::RateW-1:0]   rate;
    int                           pick;
    int                           span;
    tcoc_pkg::vec_t               x;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin thr = tcoc_pkg::ThreshReset; rate = tcoc_pkg::RateReset; end
        1: begin thr = '0; rate = tcoc_pkg::RateW'($urandom); end
        2: begin thr = {tcoc_pkg::ThreshW{1'b1}}; rate = {tcoc_pkg::RateW{1'b1}}; end
        3: begin thr = tcoc_pkg::ThreshW'($urandom_range(1, 32767)); rate = '0; end
        4: begin
          thr  = tcoc_pkg::ThreshW'($urandom_range(50, 2000));
          rate = tcoc_pkg::RateW'($urandom);
        end
        5: begin thr = tcoc_pkg::ThreshW'($urandom); rate = tcoc_pkg::RateW'($urandom); end
        default: begin thr = 15'd4096; rate = 16'd1; end
      endcase
      configure(thr, rate);
      span = int'(thr_reg) / 3 + 8;
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        x = ($urandom_range(0, 1) != 0) ? random_vec() : near_vec('0, 4096);
        if (pick < 6)
          send_item(tcoc_pkg::CmdLoadA, x);
        else if (pick < 12)
          send_item(tcoc_pkg::CmdLoadB, x);
        else if (pick < 20)
          send_item(tcoc_pkg::CmdTrainA,
                    ($urandom_range(0, 1) != 0) ? x : near_vec(track_a, span));
        else if (pick < 28)
          send_item(tcoc_pkg::CmdTrainB,
                    ($urandom_range(0, 1) != 0) ? x : near_vec(track_b, span));
        else if (pick < 32)
          send_item(tcoc_pkg::CmdW'($urandom_range(CmdFirstUndef, CmdLastUndef)), x);
        else if (pick < 55)
          send_item(tcoc_pkg::CmdClassify, near_vec(track_a, span));
        else if (pick < 78)
          send_item(tcoc_pkg::CmdClassify, near_vec(track_b, span));
        else
          send_item(tcoc_pkg::CmdClassify, random_vec());
        pace_sender();
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    configure(15'd8192, 16'd20000);
    rx_hold = 200;
    for (int n = 0; n < 40; n++) begin
      if (n % 3 == 0) send_item(tcoc_pkg::CmdTrainA, near_vec(track_a, 3000));
      else send_item(tcoc_pkg::CmdClassify, near_vec((n % 2 != 0) ? track_a : track_b, 3000));
    end
  endtask

  // Receiver: long hold-offs on request, otherwise a stall pattern that changes now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 150);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        RxFree:   out_ch.ready <= 1'b1;
        RxCoin:   out_ch.ready <= ($urandom_range(0, 1) != 0);
        RxSparse: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  out_ch.ready <= (rx_phase % 5) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    tcoc_pkg::merge_res_t want;
    tcoc_pkg::vec_t       got_a, got_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_a = {out_ch.cent_a3, out_ch.cent_a2, out_ch.cent_a1, out_ch.cent_a0};
      got_b = {out_ch.cent_b3, out_ch.cent_b2, out_ch.cent_b1, out_ch.cent_b0};
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.label !== want.label)
          report_mismatch($sformatf("label: got %h, expected %h", out_ch.label, want.label));
        for (int i = 0; i < tcoc_pkg::VecLen; i++) begin
          if (got_a[i] !== want.cent_a[i])
            report_mismatch($sformatf("cent_a%0d: got %h, expected %h",
                                      i, got_a[i], want.cent_a[i]));
          if (got_b[i] !== want.cent_b[i])
            report_mismatch($sformatf("cent_b%0d: got %h, expected %h",
                                      i, got_b[i], want.cent_b[i]));
        end
      end
      if (out_ch.label <= tcoc_pkg::LabelB) label_hits[out_ch.label]++;
      results_seen++;
    end
  end

  // Watchdog: any transfer on either channel or the register port counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d cycles without progress", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= tcoc_pkg::CmdClassify;
    in_ch.elem0  <= '0;
    in_ch.elem1  <= '0;
    in_ch.elem2  <= '0;
    in_ch.elem3  <= '0;
    thr_reg  = tcoc_pkg::ThreshReset;
    rate_reg = tcoc_pkg::RateReset;
    track_a  = '0;
    track_b  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_commands();
    test_threshold_edges();
    test_random_stream();
    test_backpressure();

    wait_drained();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Run covered %0d items, %0d results and %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("Labels seen: %0d unknown, %0d class A, %0d class B; %0d mismatches.",
             label_hits[0], label_hits[1], label_hits[2], errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
